// ===== design/iee_pkg.sv =====
// Shared constants, types and character helpers for the infix expression evaluator.
package iee_pkg;

    localparam int NUM_DEPTH_DEF   = 32;
    localparam int OP_DEPTH_DEF    = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 48;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic load_in;
        logic digit;
        logic end_lit;
        logic set_inv;
        logic set_mal;
        logic push_op;
        logic pop_op;
        logic rd_top;
        logic rd_second;
        logic lat_y;
        logic lat_x;
        logic alu_start;
        logic wb;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic numeral;
        logic blank;
        logic is_op;
        logic last;
        logic oc_zero;
        logic prec_le;
        logic nc_lt2;
        logic nc_one;
        logic alu_done;
        logic out_busy;
    } t_sts;

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    endfunction

    function automatic logic [1:0] op_code(input logic [7:0] c);
        logic [1:0] code;
        case (c)
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            default:  code = OP_ADD;
        endcase
        return code;
    endfunction

endpackage

// ===== design/iee_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface iee_out_if #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          has_fraction;
    logic [2:0]                    status;

    modport source (output valid, output value, output has_fraction, output status,
                    input ready);
    modport sink   (input valid, input value, input has_fraction, input status,
                    output ready);
endinterface

// ===== design/iee_alu.sv =====
// Fixed-point arithmetic unit: add/sub in one pass, shift-add multiply, restoring divide.
module iee_alu #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_op,
    input  logic [VALUE_WIDTH-1:0] i_x,
    input  logic [VALUE_WIDTH-1:0] i_y,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_res,
    output logic                   o_ovf,
    output logic                   o_dz
);
    import iee_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + FRAC_BITS;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(DW + 1);
    localparam logic [VW-1:0] MAX_MAG = {1'b0, {(VW-1){1'b1}}};

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_RUN  = 2'd1;
    localparam logic [1:0] A_FIN  = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_op;
    logic          r_neg;
    logic          r_dz;
    logic [VW-1:0] r_x;
    logic [VW-1:0] r_y;
    logic [VW-1:0] r_mc;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_dq;
    logic [VW-1:0] r_rem;
    logic          r_done;
    logic [VW-1:0] r_res;
    logic          r_ovf;

    logic [VW-1:0] mag_x;
    logic [VW-1:0] mag_y;
    logic [VW:0]   mul_sum;
    logic [VW:0]   div_t;
    logic          div_ge;
    logic [VW:0]   div_sub;
    logic [PW-1:0] mag_w;
    logic [PW-1:0] lim;
    logic          md_ovf;
    logic [VW-1:0] md_res;
    logic [VW:0]   as_sum;
    logic          as_ovf;

    always_comb begin
        mag_x   = i_x[VW-1] ? (~i_x + 1'b1) : i_x;
        mag_y   = i_y[VW-1] ? (~i_y + 1'b1) : i_y;
        mul_sum = {1'b0, r_prod[PW-1:VW]} + (r_prod[0] ? {1'b0, r_mc} : '0);
        div_t   = {r_rem, r_dq[DW-1]};
        div_ge  = div_t >= {1'b0, r_mc};
        div_sub = div_t - {1'b0, r_mc};
        mag_w   = (r_op == OP_MUL) ? (r_prod >> FRAC_BITS) : PW'(r_dq);
        lim     = PW'(MAX_MAG) + PW'(r_neg);
        md_ovf  = mag_w > lim;
        md_res  = r_neg ? (~mag_w[VW-1:0] + 1'b1) : mag_w[VW-1:0];
        if (r_op == OP_SUB) begin
            as_sum = {r_x[VW-1], r_x} - {r_y[VW-1], r_y};
        end else begin
            as_sum = {r_x[VW-1], r_x} + {r_y[VW-1], r_y};
        end
        as_ovf = as_sum[VW] ^ as_sum[VW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_op  <= i_op;
                        r_x   <= i_x;
                        r_y   <= i_y;
                        r_neg <= i_x[VW-1] ^ i_y[VW-1];
                        r_dz  <= (i_op == OP_DIV) && (i_y == '0);
                        if (i_op == OP_MUL) begin
                            r_mc    <= mag_x;
                            r_prod  <= {{VW{1'b0}}, mag_y};
                            r_cnt   <= CW'(VW);
                            r_state <= A_RUN;
                        end else if (i_op == OP_DIV && i_y != '0) begin
                            r_mc    <= mag_y;
                            r_dq    <= DW'(mag_x) << FRAC_BITS;
                            r_rem   <= '0;
                            r_cnt   <= CW'(DW);
                            r_state <= A_RUN;
                        end else begin
                            r_state <= A_FIN;
                        end
                    end
                end
                A_RUN: begin
                    if (r_op == OP_MUL) begin
                        r_prod <= {mul_sum, r_prod[VW-1:1]};
                    end else begin
                        r_rem <= div_ge ? div_sub[VW-1:0] : div_t[VW-1:0];
                        r_dq  <= {r_dq[DW-2:0], div_ge};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    if (r_op == OP_ADD || r_op == OP_SUB) begin
                        r_res <= as_sum[VW-1:0];
                        r_ovf <= as_ovf;
                    end else begin
                        r_res <= md_res;
                        r_ovf <= md_ovf;
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_ovf  = r_ovf;
    assign o_dz   = r_dz;

endmodule

// ===== design/iee_datapath.sv =====
// Datapath: literal builder, number and operator stacks, error register, result register.
module iee_datapath #(
    parameter int NUM_DEPTH   = iee_pkg::NUM_DEPTH_DEF,
    parameter int OP_DEPTH    = iee_pkg::OP_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iee_pkg::t_cmd                 i_cmd,
    output iee_pkg::t_sts                 o_sts,
    input  logic [7:0]                    i_character,
    input  logic                          i_last,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_has_fraction,
    output logic [2:0]                    o_status
);
    import iee_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int LW  = VALUE_WIDTH + 4;
    localparam int NAW = (NUM_DEPTH > 1) ? $clog2(NUM_DEPTH) : 1;
    localparam int NCW = $clog2(NUM_DEPTH + 1);
    localparam int OAW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int OCW = $clog2(OP_DEPTH + 1);
    localparam logic [VW-1:0] MAX_MAG   = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] FRAC_MASK = ~({VW{1'b1}} << FRAC_BITS);

    logic [7:0]     r_char;
    logic           r_last;
    logic [VW-1:0]  r_acc;
    logic           r_in_lit;
    logic [2:0]     r_err;
    logic [2:0]     n_err;
    logic [NCW-1:0] r_nc;
    logic [OCW-1:0] r_oc;
    logic [1:0]     r_ops [OP_DEPTH];
    logic [VW-1:0]  r_mem [NUM_DEPTH];
    logic [VW-1:0]  r_rd;
    logic [VW-1:0]  r_x;
    logic [VW-1:0]  r_y;
    logic [1:0]     r_op;
    logic           r_out_valid;
    logic [VW-1:0]  r_value;
    logic           r_frac;
    logic [2:0]     r_status;

    logic [LW-1:0]  digit_val;
    logic [LW-1:0]  lit_next;
    logic           lit_ovf;
    logic           nc_full;
    logic           oc_full;
    logic [OAW-1:0] top_idx;
    logic [1:0]     top_op;
    logic [1:0]     code;
    logic [NAW-1:0] rd_addr;
    logic           we_lit;
    logic           we_wb;
    logic           push_ok;
    logic           alu_done;
    logic [VW-1:0]  alu_res;
    logic           alu_ovf;
    logic           alu_dz;

    iee_alu #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.alu_start),
        .i_op    (r_op),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (alu_done),
        .o_res   (alu_res),
        .o_ovf   (alu_ovf),
        .o_dz    (alu_dz)
    );

    always_comb begin
        digit_val = LW'(r_char - CH_ZERO) << FRAC_BITS;
        lit_next  = (LW'(r_acc) << 3) + (LW'(r_acc) << 1) + digit_val;
        lit_ovf   = lit_next > LW'(MAX_MAG);
        nc_full   = r_nc >= NCW'(NUM_DEPTH);
        oc_full   = r_oc >= OCW'(OP_DEPTH);
        top_idx   = OAW'(r_oc - 1'b1);
        top_op    = r_ops[top_idx];
        code      = op_code(r_char);
        we_lit    = i_cmd.end_lit && r_in_lit && !nc_full && (r_err == ST_OK);
        we_wb     = i_cmd.wb && !alu_dz && !alu_ovf && (r_err == ST_OK);
        push_ok   = i_cmd.push_op && !oc_full && (r_err == ST_OK);
        if (i_cmd.rd_top) begin
            rd_addr = NAW'(r_nc - 1'b1);
        end else if (i_cmd.rd_second) begin
            rd_addr = NAW'(r_nc - 2'd2);
        end else begin
            rd_addr = '0;
        end
    end

    // First error wins; emit returns the register to no-error.
    always_comb begin
        n_err = r_err;
        if (r_err == ST_OK) begin
            if (i_cmd.digit && lit_ovf) begin
                n_err = ST_OVERFLOW;
            end else if (i_cmd.end_lit && r_in_lit && nc_full) begin
                n_err = ST_OVERFLOW;
            end else if (i_cmd.push_op && oc_full) begin
                n_err = ST_OVERFLOW;
            end else if (i_cmd.set_inv) begin
                n_err = ST_INVALID;
            end else if (i_cmd.set_mal) begin
                n_err = ST_MALFORMED;
            end else if (i_cmd.wb && alu_dz) begin
                n_err = ST_DIVZERO;
            end else if (i_cmd.wb && alu_ovf) begin
                n_err = ST_OVERFLOW;
            end
        end
        if (i_cmd.emit) begin
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_lit) begin
            r_mem[r_nc[NAW-1:0]] <= r_acc;
        end else if (we_wb) begin
            r_mem[NAW'(r_nc - 2'd2)] <= alu_res;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_ops[r_oc[OAW-1:0]] <= code;
        end
        if (i_cmd.load_in) begin
            r_char <= i_character;
            r_last <= i_last;
        end
        if (i_cmd.pop_op) begin
            r_op <= top_op;
        end
        if (i_cmd.lat_y) begin
            r_y <= r_rd;
        end
        if (i_cmd.lat_x) begin
            r_x <= r_rd;
        end
        if (i_cmd.emit) begin
            r_value  <= (r_err == ST_OK) ? r_rd : '0;
            r_frac   <= (r_err == ST_OK) ? |(r_rd & FRAC_MASK) : 1'b0;
            r_status <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= ST_OK;
            r_nc        <= '0;
            r_oc        <= '0;
            r_acc       <= '0;
            r_in_lit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_err <= n_err;
            if (i_cmd.emit) begin
                r_nc     <= '0;
                r_oc     <= '0;
                r_acc    <= '0;
                r_in_lit <= 1'b0;
            end else begin
                if (we_lit) begin
                    r_nc <= r_nc + 1'b1;
                end else if (we_wb) begin
                    r_nc <= r_nc - 1'b1;
                end
                if (push_ok) begin
                    r_oc <= r_oc + 1'b1;
                end else if (i_cmd.pop_op) begin
                    r_oc <= r_oc - 1'b1;
                end
                if (i_cmd.digit && !lit_ovf && (r_err == ST_OK)) begin
                    r_acc    <= lit_next[VW-1:0];
                    r_in_lit <= 1'b1;
                end else if (i_cmd.end_lit && (r_err == ST_OK)) begin
                    r_acc    <= '0;
                    r_in_lit <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.err      = r_err != ST_OK;
        o_sts.numeral  = is_numeral(r_char);
        o_sts.blank    = r_char == CH_SPACE;
        o_sts.is_op    = is_operator(r_char);
        o_sts.last     = r_last;
        o_sts.oc_zero  = r_oc == '0;
        o_sts.prec_le  = !(code[1] && !top_op[1]);
        o_sts.nc_lt2   = r_nc < NCW'(2);
        o_sts.nc_one   = r_nc == NCW'(1);
        o_sts.alu_done = alu_done;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_has_fraction = r_frac;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_nc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nc <= NCW'(NUM_DEPTH))
        else $error("number count beyond stack depth");
    a_oc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oc <= OCW'(OP_DEPTH))
        else $error("operator count beyond stack depth");
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_nc == '0 && r_oc == '0 && r_err == ST_OK && r_out_valid))
        else $error("state not cleared after result");
    a_wb_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wb && r_err == ST_OK) |-> r_nc >= NCW'(2))
        else $error("write-back with fewer than two operands");
`endif

endmodule

// ===== design/iee_ctrl.sv =====
// Controller: sequences decode, operator reduction, drain and result emission.
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iee_pkg::t_sts i_sts,
    output iee_pkg::t_cmd o_cmd
);
    import iee_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_OPLOOP = 4'd2;
    localparam logic [3:0] S_LAST   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_RED0   = 4'd5;
    localparam logic [3:0] S_RED1   = 4'd6;
    localparam logic [3:0] S_RED2   = 4'd7;
    localparam logic [3:0] S_EXEC   = 4'd8;
    localparam logic [3:0] S_BUSY   = 4'd9;
    localparam logic [3:0] S_FINAL  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ret;
    logic       n_ret;
    logic [3:0] ret_state;

    assign ret_state  = r_ret ? S_DRAIN : S_OPLOOP;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_LAST;
                if (!i_sts.err) begin
                    if (i_sts.numeral) begin
                        o_cmd.digit = 1'b1;
                    end else if (i_sts.blank) begin
                        o_cmd.end_lit = 1'b1;
                    end else if (i_sts.is_op) begin
                        o_cmd.end_lit = 1'b1;
                        n_state       = S_OPLOOP;
                    end else begin
                        o_cmd.set_inv = 1'b1;
                    end
                end
            end
            S_OPLOOP: begin
                if (i_sts.err) begin
                    n_state = S_LAST;
                end else if (!i_sts.oc_zero && i_sts.prec_le) begin
                    n_ret   = 1'b0;
                    n_state = S_RED0;
                end else begin
                    o_cmd.push_op = 1'b1;
                    n_state       = S_LAST;
                end
            end
            S_LAST: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.err) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.end_lit = 1'b1;
                    n_state       = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.err || i_sts.oc_zero) begin
                    n_state = S_FINAL;
                end else begin
                    n_ret   = 1'b1;
                    n_state = S_RED0;
                end
            end
            S_RED0: begin
                if (i_sts.nc_lt2 || i_sts.oc_zero) begin
                    o_cmd.set_mal = 1'b1;
                    n_state       = ret_state;
                end else begin
                    o_cmd.pop_op = 1'b1;
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_RED1;
                end
            end
            S_RED1: begin
                o_cmd.lat_y     = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state         = S_RED2;
            end
            S_RED2: begin
                o_cmd.lat_x = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.alu_start = 1'b1;
                n_state         = S_BUSY;
            end
            S_BUSY: begin
                if (i_sts.alu_done) begin
                    o_cmd.wb = 1'b1;
                    n_state  = ret_state;
                end
            end
            S_FINAL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.set_mal = !i_sts.err && !i_sts.nc_one;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

// ===== design/infix_expression_evaluator_core.sv =====
// A digit or space goes through decode and the last-character check before ready returns;
// an operator also runs the operator loop and its reductions. A reduction steps through
// RED0, RED1, RED2, EXEC and BUSY, then waits on the arithmetic unit (add/sub in one pass,
// multiply and divide one bit a cycle). Final character: drain reductions, then FINAL and
// EMIT fill the result register (FINAL waits while it is full). One character at a time.
// Reset: synchronous, active low; clears counts, literal, error and handshakes; no clearing pass.
module infix_expression_evaluator_core #(
    parameter int NUM_DEPTH   = iee_pkg::NUM_DEPTH_DEF,
    parameter int OP_DEPTH    = iee_pkg::OP_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iee_in_if.sink            i_in,
    iee_out_if.source         o_out
);
    import iee_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // Sequencer: takes a transaction only when idle, then walks the character through
    // decode, reduction loop and (on the final character) drain and emit.
    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: hold the stacks, build literals, run the arithmetic unit and
    // keep the result register that parts the output side from the work.
    iee_datapath #(
        .NUM_DEPTH   (NUM_DEPTH),
        .OP_DEPTH    (OP_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_character    (i_in.character),
        .i_last         (i_in.last),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_value        (o_out.value),
        .o_has_fraction (o_out.has_fraction),
        .o_status       (o_out.status)
    );

    assign i_in.ready = in_ready;

endmodule
